[rtl/core/hcbd_pkg.sv]
`timescale 1ns / 1ps

package hcbd_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int HEX_W  = 4;

    // Parser phases, one-hot.
    typedef enum logic [5:0] {
        PH_FIRST  = 6'b000001,
        PH_HEADER = 6'b000010,
        PH_SIZE   = 6'b000100,
        PH_DATA   = 6'b001000,
        PH_TRAIL  = 6'b010000,
        PH_DONE   = 6'b100000
    } t_phase;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind K_BODY = 2'd0;
    localparam t_kind K_END  = 2'd1;
    localparam t_kind K_BAD  = 2'd2;
    localparam t_kind K_BIG  = 2'd3;

    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_H  = 8'h48;

    localparam logic [1:0] HDR_LAST  = 2'd3;
    localparam logic [1:0] TRAIL_LEN = 2'd2;

    typedef struct packed {
        logic             ok;
        logic [HEX_W-1:0] val;
    } t_hex;

    // Decodes one ASCII hex digit; ok is low for any other byte.
    function automatic t_hex hex_decode(input logic [BYTE_W-1:0] c);
        t_hex r;
        r.ok  = 1'b1;
        r.val = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.val = HEX_W'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.val = HEX_W'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.val = HEX_W'(c - 8'h37);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

[rtl/core/hcbd_in_if.sv]
`timescale 1ns / 1ps

interface hcbd_in_if;
    import hcbd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

[rtl/core/hcbd_out_if.sv]
`timescale 1ns / 1ps

interface hcbd_out_if;
    import hcbd_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] body_byte;

    modport source (output valid, output kind, output body_byte, input ready);
    modport sink   (input valid, input kind, input body_byte, output ready);
endinterface

[rtl/core/http_chunked_body_decoder_core.sv]
`timescale 1ns / 1ps
// Output timing: a result word is registered and shows on o_out in the cycle after the input word that causes it.
// Throughput: one input word per cycle; the decode is a single pass from the parser state
// and the incoming byte into the state registers and the output register.
// Input is stalled only while the output register holds a word that is not being taken.
// Reset (i_rst_n low, synchronous) returns the parser to the first-byte phase and empties
// the output register; no clearing pass is needed.

module http_chunked_body_decoder_core #(
    parameter int SIZE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hcbd_in_if.sink    i_in,
    hcbd_out_if.source o_out
);
    import hcbd_pkg::*;

    // Parser state. The size accumulator and the remaining-byte count are SIZE_BITS wide,
    // which sets the largest chunk size the decoder will accept.
    t_phase               r_phase,        n_phase;
    logic [1:0]           r_header_match, n_header_match;
    logic [SIZE_BITS-1:0] r_size_accum,   n_size_accum;
    logic                 r_digits_seen,  n_digits_seen;
    logic                 r_digits_ended, n_digits_ended;
    logic                 r_cr_pending,   n_cr_pending;
    logic [SIZE_BITS-1:0] r_bytes_left,   n_bytes_left;
    logic [1:0]           r_skip_left,    n_skip_left;

    // Output register. It is a single stage, but the input side keeps flowing whenever
    // the downstream consumer takes the held word in the same cycle.
    logic              r_out_valid;
    t_kind             r_kind;
    logic [BYTE_W-1:0] r_body;

    logic              in_acc;
    logic              out_acc;
    logic              emit;
    t_kind             emit_kind;
    logic [BYTE_W-1:0] emit_byte;

    // Size-line view of the state. A first byte other than 'H' opens a size line, so in
    // that phase the line starts from cleared fields.
    logic [SIZE_BITS-1:0] sl_accum;
    logic                 sl_seen;
    logic                 sl_ended;
    logic                 sl_cr;
    t_hex                 hex;
    logic [BYTE_W-1:0]    c;
    logic [BYTE_W-1:0]    hdr_want;
    logic [SIZE_BITS-1:0] left_dec;
    logic [1:0]           skip_dec;

    assign c       = i_in.in_byte;
    assign out_acc = r_out_valid && o_out.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc  = i_in.valid && i_in.ready;

    assign hex      = hex_decode(c);
    assign sl_accum = (r_phase == PH_FIRST) ? '0   : r_size_accum;
    assign sl_seen  = (r_phase == PH_FIRST) ? 1'b0 : r_digits_seen;
    assign sl_ended = (r_phase == PH_FIRST) ? 1'b0 : r_digits_ended;
    assign sl_cr    = (r_phase == PH_FIRST) ? 1'b0 : r_cr_pending;
    assign hdr_want = r_header_match[0] ? CH_LF : CH_CR;
    assign left_dec = r_bytes_left - SIZE_BITS'(1);
    assign skip_dec = (r_skip_left != 2'd0) ? r_skip_left - 2'd1 : 2'd0;

    always_comb begin
        n_phase        = r_phase;
        n_header_match = r_header_match;
        n_size_accum   = r_size_accum;
        n_digits_seen  = r_digits_seen;
        n_digits_ended = r_digits_ended;
        n_cr_pending   = r_cr_pending;
        n_bytes_left   = r_bytes_left;
        n_skip_left    = r_skip_left;
        emit           = 1'b0;
        emit_kind      = K_BODY;
        emit_byte      = '0;

        // The size-line handler is shared by the first-byte and size phases.
        if ((r_phase == PH_FIRST && c != CH_H) || r_phase == PH_SIZE) begin
            n_phase        = PH_SIZE;
            n_size_accum   = sl_accum;
            n_digits_seen  = sl_seen;
            n_digits_ended = sl_ended;
            if (sl_cr && c == CH_LF) begin
                // End of the size line: decide between bad line, end of body and data.
                n_cr_pending = 1'b0;
                if (!sl_seen) begin
                    n_phase   = PH_DONE;
                    emit      = 1'b1;
                    emit_kind = K_BAD;
                end else if (sl_accum == '0) begin
                    n_phase   = PH_DONE;
                    emit      = 1'b1;
                    emit_kind = K_END;
                end else begin
                    n_bytes_left = sl_accum;
                    n_phase      = PH_DATA;
                end
            end else begin
                n_cr_pending = (c == CH_CR);
                if (!hex.ok) begin
                    n_digits_ended = 1'b1;
                end else if (!sl_ended) begin
                    // A digit that would shift a set bit out of the accumulator is an error.
                    if (sl_accum[SIZE_BITS-1 -: HEX_W] != '0) begin
                        n_phase   = PH_DONE;
                        emit      = 1'b1;
                        emit_kind = K_BIG;
                    end else begin
                        n_size_accum  = {sl_accum[SIZE_BITS-HEX_W-1:0], hex.val};
                        n_digits_seen = 1'b1;
                    end
                end
            end
        end else begin
            case (r_phase)
                PH_FIRST: begin
                    // Only an 'H' reaches here: a header precedes the body.
                    n_phase        = PH_HEADER;
                    n_header_match = '0;
                end
                PH_HEADER: begin
                    // Track progress through CR LF CR LF; a stray CR restarts at one.
                    if (c == hdr_want) begin
                        if (r_header_match == HDR_LAST) begin
                            n_header_match = '0;
                            n_phase        = PH_SIZE;
                            n_size_accum   = '0;
                            n_digits_seen  = 1'b0;
                            n_digits_ended = 1'b0;
                            n_cr_pending   = 1'b0;
                        end else begin
                            n_header_match = r_header_match + 2'd1;
                        end
                    end else begin
                        n_header_match = (c == CH_CR) ? 2'd1 : 2'd0;
                    end
                end
                PH_DATA: begin
                    n_bytes_left = left_dec;
                    if (left_dec == '0) begin
                        n_phase     = PH_TRAIL;
                        n_skip_left = TRAIL_LEN;
                    end
                    emit      = 1'b1;
                    emit_kind = K_BODY;
                    emit_byte = c;
                end
                PH_TRAIL: begin
                    // The two bytes closing a chunk are dropped whatever they hold.
                    n_skip_left = skip_dec;
                    if (skip_dec == 2'd0) begin
                        n_phase        = PH_SIZE;
                        n_size_accum   = '0;
                        n_digits_seen  = 1'b0;
                        n_digits_ended = 1'b0;
                        n_cr_pending   = 1'b0;
                    end
                end
                default: begin
                    // Done: every byte is consumed without a result.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_FIRST;
            r_header_match <= '0;
            r_size_accum   <= '0;
            r_digits_seen  <= 1'b0;
            r_digits_ended <= 1'b0;
            r_cr_pending   <= 1'b0;
            r_bytes_left   <= '0;
            r_skip_left    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase        <= n_phase;
                r_header_match <= n_header_match;
                r_size_accum   <= n_size_accum;
                r_digits_seen  <= n_digits_seen;
                r_digits_ended <= n_digits_ended;
                r_cr_pending   <= n_cr_pending;
                r_bytes_left   <= n_bytes_left;
                r_skip_left    <= n_skip_left;
            end
            if (in_acc && emit) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of the output register needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc && emit) begin
            r_kind <= emit_kind;
            r_body <= emit_byte;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.kind      = r_kind;
    assign o_out.body_byte = r_body;

    // A terminating word is only ever loaded together with the move to the done phase.
    a_term_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != K_BODY) |-> (r_phase == PH_DONE))
        else $error("terminating word held outside done phase");

    // The data phase always has at least one byte left to pass.
    a_data_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_bytes_left != '0))
        else $error("data phase with zero bytes left");

    // The trailer phase always has a byte left to skip.
    a_trail_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TRAIL) |-> (r_skip_left != 2'd0))
        else $error("trailer phase with nothing to skip");

    // Once done, the parser stays done and produces no further words.
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_phase == PH_DONE) |=> (r_phase == PH_DONE && !$rose(r_out_valid)))
        else $error("activity after end of body");

endmodule

[tb/http_chunked_body_decoder_core_tb.sv]
`timescale 1ns / 1ps

module http_chunked_body_decoder_core_tb;
    import hcbd_pkg::*;

    localparam int SIZE_BITS     = 32;
    localparam int ITEM_TARGET   = 1400;
    localparam int MAX_IDLE      = 18;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_PRINTED   = 50;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] body;
    } t_word;

    // Tracks the decoder state on every accepted byte and keeps the words it
    // should produce, oldest first.
    class chunk_scoreboard;
        t_phase                phase;
        logic [1:0]            hdr_match;
        logic [SIZE_BITS-1:0]  size_accum;
        bit                    digits_seen;
        bit                    digits_ended;
        bit                    cr_pending;
        logic [SIZE_BITS-1:0]  bytes_left;
        logic [1:0]            skip_left;
        t_word                 expected_words[$];
        int                    errors;

        function new();
            phase        = PH_FIRST;
            hdr_match    = '0;
            size_accum   = '0;
            digits_seen  = 1'b0;
            digits_ended = 1'b0;
            cr_pending   = 1'b0;
            bytes_left   = '0;
            skip_left    = '0;
            errors       = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void push_word(t_kind kind, logic [BYTE_W-1:0] body);
            t_word w;
            w.kind = kind;
            w.body = body;
            expected_words.push_back(w);
        endfunction

        function void open_size_line();
            phase        = PH_SIZE;
            size_accum   = '0;
            digits_seen  = 1'b0;
            digits_ended = 1'b0;
            cr_pending   = 1'b0;
        endfunction

        function int digit_of(logic [BYTE_W-1:0] c);
            if (c >= "0" && c <= "9") return int'(c) - int'("0");
            if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
            if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
            return -1;
        endfunction

        function void size_line_byte(logic [BYTE_W-1:0] c);
            int h;
            // CR LF closes the line; what the line held decides the outcome.
            if (cr_pending && c == CH_LF) begin
                if (!digits_seen) begin
                    phase = PH_DONE;
                    push_word(K_BAD, '0);
                end else if (size_accum == '0) begin
                    phase = PH_DONE;
                    push_word(K_END, '0);
                end else begin
                    bytes_left = size_accum;
                    phase      = PH_DATA;
                end
                return;
            end
            cr_pending = (c == CH_CR);
            h = digit_of(c);
            if (h < 0) begin
                digits_ended = 1'b1;
            end else if (!digits_ended) begin
                // A set bit in the top digit would be shifted out.
                if (size_accum[SIZE_BITS-1 -: HEX_W] != '0) begin
                    phase = PH_DONE;
                    push_word(K_BIG, '0);
                    return;
                end
                size_accum  = {size_accum[SIZE_BITS-HEX_W-1:0], HEX_W'(h)};
                digits_seen = 1'b1;
            end
        endfunction

        function void note_input(logic [BYTE_W-1:0] c);
            logic [BYTE_W-1:0] want;
            case (phase)
                PH_FIRST: begin
                    if (c == CH_H) begin
                        phase     = PH_HEADER;
                        hdr_match = '0;
                    end else begin
                        open_size_line();
                        size_line_byte(c);
                    end
                end
                PH_HEADER: begin
                    want = hdr_match[0] ? CH_LF : CH_CR;
                    if (c == want) begin
                        if (hdr_match == HDR_LAST) begin
                            hdr_match = '0;
                            open_size_line();
                        end else begin
                            hdr_match = hdr_match + 2'd1;
                        end
                    end else begin
                        hdr_match = (c == CH_CR) ? 2'd1 : 2'd0;
                    end
                end
                PH_SIZE: size_line_byte(c);
                PH_DATA: begin
                    bytes_left = bytes_left - 1'b1;
                    if (bytes_left == '0) begin
                        phase     = PH_TRAIL;
                        skip_left = TRAIL_LEN;
                    end
                    push_word(K_BODY, c);
                end
                PH_TRAIL: begin
                    if (skip_left != '0) skip_left = skip_left - 2'd1;
                    if (skip_left == '0) open_size_line();
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_output(t_kind kind, logic [BYTE_W-1:0] body);
            t_word want;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("word kind %0d byte %02h with nothing expected",
                                          kind, body));
                return;
            end
            want = expected_words.pop_front();
            if (kind !== want.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
            if (body !== want.body)
                report_mismatch($sformatf("body byte %02h, expected %02h", body, want.body));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    hcbd_in_if  in_if ();
    hcbd_out_if out_if ();

    http_chunked_body_decoder_core #(
        .SIZE_BITS(SIZE_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    chunk_scoreboard sb = new();
    int              byte_count  = 0;
    int unsigned     cycle_count = 0;
    bit              steady_flow;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Alternates stretches of random idling with stretches at full rate.
    initial begin
        steady_flow = 1'b0;
        forever begin
            repeat ($urandom_range(100, 400)) @(posedge i_clk);
            steady_flow = !steady_flow;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, sb.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Output side: outside the full-rate stretches, stalls a random while before taking each word.
    initial begin : result_sink
        int gap;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = steady_flow ? 0 : $urandom_range(0, MAX_IDLE);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_if.valid) @(posedge i_clk);
            sb.check_output(out_if.kind, out_if.body_byte);
            @(negedge i_clk);
        end
    end

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return 8'h30 + v;
        return (upper ? 8'h41 : 8'h61) + v - 8'd10;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_input(b);
        byte_count++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_line_end();
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // Size line with optional leading zeros, mixed-case digits and an
    // extension that may carry stray hex digits and a lone CR.
    task automatic send_size_line(input int unsigned chunk_len);
        int unsigned       rest;
        int                count;
        logic [3:0]        nibs[8];
        logic [BYTE_W-1:0] prev;
        logic [BYTE_W-1:0] b;
        rest  = chunk_len;
        count = 0;
        do begin
            nibs[count] = 4'(rest);
            rest        = rest >> 4;
            count++;
        end while (rest != 0);
        repeat ($urandom_range(0, 3)) send_byte("0");
        for (int i = count - 1; i >= 0; i--)
            send_byte(hex_char(nibs[i], 1'($urandom_range(0, 1))));
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 3))
                0:       prev = ";";
                1:       prev = " ";
                2:       prev = 8'h09;
                default: prev = CH_CR;
            endcase
            send_byte(prev);
            repeat ($urandom_range(0, 8)) begin
                b = BYTE_W'($urandom_range(0, 255));
                // Keep the line from closing inside the extension.
                if (prev == CH_CR && b == CH_LF) b = "x";
                send_byte(b);
                prev = b;
            end
        end
        send_line_end();
    endtask

    // Holds the input idle until every expected word has come out.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int                sel;
        int                len;
        int unsigned       chunk_len;
        t_kind             ending;
        bit                mid_pause_done;
        logic [BYTE_W-1:0] b;

        in_if.valid   = 1'b0;
        in_if.in_byte = '0;
        i_rst_n       = 1'b0;
        mid_pause_done = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Most runs start with a header; otherwise the first byte opens a size line.
        if ($urandom_range(0, 3) != 0) begin
            send_text("HTTP/1.1");
            repeat ($urandom_range(1, 3)) begin
                sel = $urandom_range(0, 2);
                // Near misses of the blank line: CR CR LF, and CR LF CR then text.
                send_byte(CH_CR);
                if (sel == 1) send_byte(CH_CR);
                send_byte(CH_LF);
                if (sel == 2) send_byte(CH_CR);
                len = $urandom_range(1, 6);
                repeat (len) begin
                    b = BYTE_W'($urandom_range(0, 255));
                    if (b == CH_CR || b == CH_LF) b = "-";
                    send_byte(b);
                end
            end
            send_line_end();
            send_line_end();
        end

        // Extremes of the data byte and a size line with ignored hex after a ';' and a stray CR.
        send_text("1");
        send_line_end();
        send_byte(8'h00);
        send_line_end();
        send_text("2;aF");
        send_byte(CH_CR);
        send_text("x");
        send_line_end();
        send_byte(8'hFF);
        send_byte(8'h80);
        send_text("zz");
        send_text("00B");
        send_line_end();
        for (int i = 0; i < 8; i++) send_byte(8'h01 << i);
        send_byte(8'h7F);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_line_end();
        wait_drained();

        // Well-formed chunks with random content, mostly short.
        while (byte_count < ITEM_TARGET) begin
            if (!mid_pause_done && byte_count >= ITEM_TARGET / 2) begin
                wait_drained();
                mid_pause_done = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 80)      chunk_len = $urandom_range(1, 16);
            else if (sel < 95) chunk_len = $urandom_range(17, 64);
            else               chunk_len = $urandom_range(65, 300);
            send_size_line(chunk_len);
            repeat (chunk_len) send_byte(BYTE_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 6) != 0) begin
                send_line_end();
            end else begin
                send_byte(BYTE_W'($urandom_range(0, 255)));
                send_byte(BYTE_W'($urandom_range(0, 255)));
            end
        end

        // Only one way out per run, since reset is never asserted again.
        case ($urandom_range(0, 2))
            0:       ending = K_END;
            1:       ending = K_BAD;
            default: ending = K_BIG;
        endcase
        case (ending)
            K_END: begin
                repeat ($urandom_range(1, 3)) send_byte("0");
                if ($urandom_range(0, 1) != 0) send_text(";last");
                send_line_end();
            end
            K_BAD: begin
                sel = $urandom_range(0, 2);
                if (sel == 1) send_text("; 1f");
                else if (sel == 2) send_byte(CH_CR);
                send_line_end();
            end
            default: begin
                // Nine significant digits overflow a 32-bit size.
                repeat ($urandom_range(0, 2)) send_byte("0");
                send_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
                repeat (8)
                    send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
                send_line_end();
            end
        endcase
        // Everything after the end must be swallowed.
        repeat (40) send_byte(BYTE_W'($urandom_range(0, 255)));

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
